@@ hdl/fbpa_pkg.sv @@
`timescale 1ns / 1ps

package fbpa_pkg;

    // item opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_FOREIGN   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BSL   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TOTAL = 2'd2;

    // register reset values
    localparam logic [31:0] RST_BASE  = 32'd0;
    localparam logic [4:0]  RST_BSL   = 5'd4;
    localparam logic [10:0] RST_TOTAL = 11'd1024;

    // controller to datapath
    typedef struct packed {
        logic take;   // word accepted on the input this cycle
        logic link;   // allocate completes with the link read back
        logic sweep;  // clear one entry of the link store
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic slot_free;   // output register free or being emptied
        logic go_link;     // offered word is an allocate that will succeed
        logic go_sweep;    // offered word is a clear
        logic sweep_last;  // sweep at the final entry
    } t_sts;

endpackage

@@ hdl/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps

// Allocate: the accepted word reads the link store into its read register, then the
// result register is loaded; free, clear, errors and unused opcodes load the result
// register directly. No new word is taken while an allocate waits on the link read; one
// free per cycle while the result stream takes results. A clear stalls the input while
// the store is swept. Reset: synchronous, active low; the link store is then swept.
module fixed_block_pool_allocator #(
    parameter int unsigned MAX_BLOCKS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [fbpa_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    // request stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,  // request_bytes[15:0], free_address[47:16]
    input  logic [1:0]                  s_axis_tuser,  // opcode[1:0]
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [55:0]                 m_axis_tdata,  // block_address[31:0],
                                                       // block_index[41:32],
                                                       // free_blocks[52:42]
    output logic [1:0]                  m_axis_tuser   // status[1:0]
);

    fbpa_pkg::t_cmd cmd;
    fbpa_pkg::t_sts sts;

    fbpa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ hdl/fbpa_ctrl.sv @@
`timescale 1ns / 1ps

module fbpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  fbpa_pkg::t_sts i_sts,
    output fbpa_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_LINK
    } t_state;

    t_state r_state;
    t_state n_state;

    // handshake and commands
    always_comb begin
        s_axis_tready = (r_state == S_IDLE) && i_sts.slot_free;
        o_cmd.take    = s_axis_tready && s_axis_tvalid;
        o_cmd.link    = (r_state == S_LINK);
        o_cmd.sweep   = (r_state == S_SWEEP);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd.take && i_sts.go_link) begin
                    n_state = S_LINK;
                end else if (o_cmd.take && i_sts.go_sweep) begin
                    n_state = S_SWEEP;
                end
            end
            S_LINK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register; reset starts with a sweep of the link store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/fbpa_dp.sv @@
`timescale 1ns / 1ps

module fbpa_dp #(
    parameter int unsigned MAX_BLOCKS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbpa_pkg::t_cmd                i_cmd,
    output fbpa_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [fbpa_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic [47:0]                   s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [55:0]                   m_axis_tdata,
    output logic [1:0]                    m_axis_tuser
);

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned HW = IW + 1;
    localparam int unsigned NW = (HW > 11) ? HW : 11;
    localparam int unsigned RST_COUNT = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;

    // configuration
    logic [31:0] r_base;
    logic [4:0]  r_bsl;
    logic [10:0] r_total;

    // allocator state
    logic [HW-1:0] r_head;
    logic [10:0]   r_count;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_sweep_idx;

    // link store: valid mark over link index
    logic [IW:0] r_mem [MAX_BLOCKS];
    logic [IW:0] r_rdata;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_addr;
    logic [9:0]  r_out_idx;
    logic [10:0] r_out_free;

    // item fields
    logic [1:0]  op;
    logic [15:0] req;
    logic [31:0] faddr;

    logic [NW-1:0] nblk;
    logic          too_large;
    logic          empty;
    logic [31:0]   off;
    logic [31:0]   low_mask;
    logic [31:0]   bi32;
    logic          foreign;
    logic [IW-1:0] bi;
    logic [IW-1:0] addr_idx;
    logic [31:0]   idx32;
    logic [31:0]   blk_addr;

    logic [HW-1:0] n_head;
    logic [10:0]   n_count;
    logic          n_load;
    logic [1:0]    n_status;
    logic [31:0]   n_addr;
    logic [9:0]    n_idx;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW:0]   mem_wdata;
    logic          mem_re;

    assign op    = s_axis_tuser;
    assign req   = s_axis_tdata[15:0];
    assign faddr = s_axis_tdata[47:16];

    // pool size clipped to the store depth
    assign nblk = (NW'(r_total) > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(r_total);

    // allocate checks; blocks of 2^16 bytes or more take any request
    assign too_large = (r_bsl < 5'd16) && ({1'b0, req} > (17'd1 << r_bsl[3:0]));
    assign empty     = (r_count == 11'd0) || (NW'(r_head) >= nblk);

    // free checks
    assign off      = faddr - r_base;
    assign low_mask = ~(32'hFFFF_FFFF << r_bsl);
    assign bi32     = off >> r_bsl;
    assign foreign  = (|(off & low_mask)) || (bi32 >= 32'(nblk));
    assign bi       = bi32[IW-1:0];

    // block address of the freed block or of the block being handed out
    assign addr_idx = i_cmd.link ? r_cur : bi;
    assign idx32    = 32'(addr_idx);
    assign blk_addr = r_base + (idx32 << r_bsl);

    // status for the controller
    assign o_sts.slot_free  = !r_out_valid || m_axis_tready;
    assign o_sts.go_link    = (op == fbpa_pkg::OP_ALLOC) && !too_large && !empty;
    assign o_sts.go_sweep   = (op == fbpa_pkg::OP_CLEAR);
    assign o_sts.sweep_last = (r_sweep_idx == IW'(MAX_BLOCKS - 1));

    // item evaluation
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_load    = 1'b0;
        n_status  = fbpa_pkg::ST_OK;
        n_addr    = 32'd0;
        n_idx     = 10'd0;
        mem_we    = 1'b0;
        mem_waddr = r_sweep_idx;
        mem_wdata = '0;
        mem_re    = 1'b0;
        if (i_cmd.sweep) begin
            mem_we = 1'b1;
        end
        if (i_cmd.link) begin
            // follow the stored link, else step to the next block in order
            n_head   = r_rdata[IW] ? {1'b0, r_rdata[IW-1:0]} : ({1'b0, r_cur} + HW'(1));
            n_count  = r_count - 11'd1;
            n_load   = 1'b1;
            n_addr   = blk_addr;
            n_idx    = idx32[9:0];
        end else if (i_cmd.take) begin
            unique case (op)
                fbpa_pkg::OP_ALLOC: begin
                    if (too_large) begin
                        n_load   = 1'b1;
                        n_status = fbpa_pkg::ST_TOO_LARGE;
                    end else if (empty) begin
                        n_load   = 1'b1;
                        n_status = fbpa_pkg::ST_EMPTY;
                    end else begin
                        mem_re = 1'b1;
                    end
                end
                fbpa_pkg::OP_FREE: begin
                    n_load = 1'b1;
                    if (foreign) begin
                        n_status = fbpa_pkg::ST_FOREIGN;
                    end else begin
                        // head past the end links to block zero
                        mem_we    = 1'b1;
                        mem_waddr = bi;
                        mem_wdata = {1'b1, ((r_head >= HW'(MAX_BLOCKS)) ? IW'(0)
                                                                        : r_head[IW-1:0])};
                        n_head    = {1'b0, bi};
                        if (NW'(r_count) < nblk) begin
                            n_count = r_count + 11'd1;
                        end
                        n_addr = blk_addr;
                        n_idx  = idx32[9:0];
                    end
                end
                fbpa_pkg::OP_CLEAR: begin
                    n_load  = 1'b1;
                    n_head  = '0;
                    n_count = nblk[10:0];
                end
                default: begin
                    n_load = 1'b1;
                end
            endcase
        end
    end

    // configuration, allocator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= fbpa_pkg::RST_BASE;
            r_bsl       <= fbpa_pkg::RST_BSL;
            r_total     <= fbpa_pkg::RST_TOTAL;
            r_head      <= '0;
            r_count     <= 11'(RST_COUNT);
            r_sweep_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fbpa_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                    fbpa_pkg::CFG_BSL:   r_bsl   <= i_cfg_data[4:0];
                    fbpa_pkg::CFG_TOTAL: r_total <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.take && o_sts.go_sweep) begin
                r_sweep_idx <= '0;
            end else if (i_cmd.sweep) begin
                r_sweep_idx <= o_sts.sweep_last ? IW'(0) : (r_sweep_idx + IW'(1));
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and current head index
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_status <= n_status;
            r_out_addr   <= n_addr;
            r_out_idx    <= n_idx;
            r_out_free   <= n_count;
        end
        if (mem_re) begin
            r_cur <= r_head[IW-1:0];
        end
    end

    // link store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_head[IW-1:0]];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {3'b000, r_out_free, r_out_idx, r_out_addr};

endmodule
